[rtl/core/assert_macros.svh]
// Assertion macros for the checker file of the matrix inverse unit.
// Needs nothing else; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle, outside reset.
`define MI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the next cycle, outside reset.
`define MI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// The property is checked at every clock edge, including those in reset.
`define MI_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/core/mi_pkg.sv]
// Package of the 3x3 matrix inverse unit: cofactor index table and the
// status structs passed between the front end, the queue and the back end.
package mi_pkg;

   localparam int NUM_ELEMS = 9;
   localparam int NUM_PRODS = 18;

   // Each cofactor is elem[a]*elem[b] - elem[c]*elem[d]; rows give {a, b, c, d}.
   localparam int MINOR_IDX [NUM_ELEMS][4] = '{
      '{4, 8, 7, 5}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
      '{6, 5, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 0, 5},
      '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
   };

   // Fill state of the queue between front and back end.
   typedef struct packed {
      logic full;
      logic empty;
   } mi_fifo_status_type;

   // Determinant classification carried with each queued item.
   typedef struct packed {
      logic singular;
      logic det_neg;
   } mi_det_flags_type;

   localparam int FLAG_BITS = $bits(mi_det_flags_type);

endpackage

[rtl/core/mat3_if.sv]
// Valid/ready channel interfaces for the matrix inverse unit.
// Stand-alone; the request carries a matrix, the response its inverse.
interface mat3_req_if #(parameter int ELEM_WIDTH = 32) ();
   logic valid;
   logic ready;
   logic signed [ELEM_WIDTH-1:0] col0_row0;
   logic signed [ELEM_WIDTH-1:0] col0_row1;
   logic signed [ELEM_WIDTH-1:0] col0_row2;
   logic signed [ELEM_WIDTH-1:0] col1_row0;
   logic signed [ELEM_WIDTH-1:0] col1_row1;
   logic signed [ELEM_WIDTH-1:0] col1_row2;
   logic signed [ELEM_WIDTH-1:0] col2_row0;
   logic signed [ELEM_WIDTH-1:0] col2_row1;
   logic signed [ELEM_WIDTH-1:0] col2_row2;

   modport source (output valid, col0_row0, col0_row1, col0_row2, col1_row0, col1_row1,
                   col1_row2, col2_row0, col2_row1, col2_row2, input ready);
   modport sink (input valid, col0_row0, col0_row1, col0_row2, col1_row0, col1_row1,
                 col1_row2, col2_row0, col2_row1, col2_row2, output ready);
endinterface

interface mat3_rsp_if #(parameter int ELEM_WIDTH = 32) ();
   logic valid;
   logic ready;
   logic signed [ELEM_WIDTH-1:0] inv_col0_row0;
   logic signed [ELEM_WIDTH-1:0] inv_col0_row1;
   logic signed [ELEM_WIDTH-1:0] inv_col0_row2;
   logic signed [ELEM_WIDTH-1:0] inv_col1_row0;
   logic signed [ELEM_WIDTH-1:0] inv_col1_row1;
   logic signed [ELEM_WIDTH-1:0] inv_col1_row2;
   logic signed [ELEM_WIDTH-1:0] inv_col2_row0;
   logic signed [ELEM_WIDTH-1:0] inv_col2_row1;
   logic signed [ELEM_WIDTH-1:0] inv_col2_row2;
   logic singular;
   logic saturated;

   modport source (output valid, inv_col0_row0, inv_col0_row1, inv_col0_row2,
                   inv_col1_row0, inv_col1_row1, inv_col1_row2, inv_col2_row0,
                   inv_col2_row1, inv_col2_row2, singular, saturated, input ready);
   modport sink (input valid, inv_col0_row0, inv_col0_row1, inv_col0_row2,
                 inv_col1_row0, inv_col1_row1, inv_col1_row2, inv_col2_row0,
                 inv_col2_row1, inv_col2_row2, singular, saturated, output ready);
endinterface

[rtl/core/mi_front.sv]
// Front end: accepts matrices, forms cofactors and the determinant in four
// stages and pushes them into the queue. Depends on mi_pkg and mat3_req_if.
module mi_front import mi_pkg::*; #(
   parameter int ELEM_WIDTH = 32,
   localparam int CW = 2 * ELEM_WIDTH + 1,
   localparam int DW = 3 * ELEM_WIDTH + 2,
   localparam int QW = NUM_ELEMS * CW + DW + FLAG_BITS
) (
   input  logic               clock,
   input  logic               reset,
   mat3_req_if.sink           req_chan,
   input  mi_fifo_status_type q_status,
   output logic               q_push,
   output logic [QW-1:0]      q_data
);

   localparam int EW = ELEM_WIDTH;
   localparam int PW = 2 * ELEM_WIDTH;
   localparam int HW = 2 * ELEM_WIDTH + 1;

   logic signed [EW-1:0] elem [NUM_ELEMS];
   logic                 front_adv;
   logic [4:1]           vld_ff;

   logic signed [PW-1:0] prod_in [NUM_PRODS];
   logic signed [PW-1:0] prod_ff [NUM_PRODS];
   logic signed [EW-1:0] row1_ff [3];
   logic signed [EW-1:0] row2_ff [3];
   logic signed [CW-1:0] cof2_in [NUM_ELEMS];
   logic signed [CW-1:0] cof2_ff [NUM_ELEMS];
   logic signed [CW-1:0] cof3_ff [NUM_ELEMS];
   logic signed [CW-1:0] cof4_ff [NUM_ELEMS];
   logic signed [HW-1:0] lo_in [3];
   logic signed [HW-1:0] hi_in [3];
   logic signed [HW-1:0] lo_ff [3];
   logic signed [HW-1:0] hi_ff [3];
   logic signed [DW-1:0] det_in;
   logic signed [DW-1:0] det_ff;
   logic [DW-1:0]        det_mag;
   mi_det_flags_type     flags;

   assign elem[0] = req_chan.col0_row0;
   assign elem[1] = req_chan.col0_row1;
   assign elem[2] = req_chan.col0_row2;
   assign elem[3] = req_chan.col1_row0;
   assign elem[4] = req_chan.col1_row1;
   assign elem[5] = req_chan.col1_row2;
   assign elem[6] = req_chan.col2_row0;
   assign elem[7] = req_chan.col2_row1;
   assign elem[8] = req_chan.col2_row2;

   // The whole front end moves together unless its last stage cannot push.
   assign front_adv      = !(vld_ff[4] && q_status.full);
   assign req_chan.ready = front_adv;
   assign q_push         = vld_ff[4] && front_adv;

   // Stage one: the eighteen element products of the 2x2 minors.
   always_comb begin
      for (int k = 0; k < NUM_ELEMS; k++) begin
         prod_in[2*k]   = elem[MINOR_IDX[k][0]] * elem[MINOR_IDX[k][1]];
         prod_in[2*k+1] = elem[MINOR_IDX[k][2]] * elem[MINOR_IDX[k][3]];
      end
   end

   // Stage two: minor differences, exact with one extra bit.
   always_comb begin
      for (int k = 0; k < NUM_ELEMS; k++) begin
         cof2_in[k] = {prod_ff[2*k][PW-1], prod_ff[2*k]}
                    - {prod_ff[2*k+1][PW-1], prod_ff[2*k+1]};
      end
   end

   // Stage three: first-row products split at the element width of the cofactor.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         lo_in[j] = row2_ff[j] * $signed({1'b0, cof2_ff[j][EW-1:0]});
         hi_in[j] = row2_ff[j] * $signed(cof2_ff[j][CW-1:EW]);
      end
   end

   // Stage four: the determinant as the sum of the partial products.
   always_comb begin
      det_in = '0;
      for (int j = 0; j < 3; j++) begin
         det_in = det_in + (DW'(hi_ff[j]) <<< EW) + DW'(lo_ff[j]);
      end
   end

   // Classify the determinant and pack the queue entry.
   always_comb begin
      det_mag        = det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
      flags.singular = (det_ff == '0);
      flags.det_neg  = det_ff[DW-1];
      for (int k = 0; k < NUM_ELEMS; k++) begin
         q_data[k*CW +: CW] = cof4_ff[k];
      end
      q_data[NUM_ELEMS*CW +: DW]        = det_mag;
      q_data[NUM_ELEMS*CW+DW +: FLAG_BITS] = flags;
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (front_adv) begin
         vld_ff <= {vld_ff[3:1], req_chan.valid};
      end
   end

   // Stage payload registers.
   always_ff @(posedge clock) begin
      if (front_adv) begin
         prod_ff <= prod_in;
         row1_ff <= '{elem[0], elem[3], elem[6]};
         cof2_ff <= cof2_in;
         row2_ff <= row1_ff;
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         cof3_ff <= cof2_ff;
         det_ff  <= det_in;
         cof4_ff <= cof3_ff;
      end
   end

endmodule

[rtl/core/mi_queue.sv]
// Short first-in first-out queue that decouples the front and back ends.
// Depends on mi_pkg for its status struct.
module mi_queue import mi_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [WIDTH-1:0]   push_data,
   input  logic               pop,
   output logic [WIDTH-1:0]   pop_data,
   output mi_fifo_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign pop_data      = mem_ff[rd_ptr_ff];
   assign status.full   = (count_ff == CNT_W'(DEPTH));
   assign status.empty  = (count_ff == '0);

   // Pointer and fill count update; pointers wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/mi_back.sv]
// Back end: scales the cofactors, divides them by the determinant one
// quotient bit a stage, saturates and holds the result. Depends on mi_pkg.
module mi_back import mi_pkg::*; #(
   parameter int ELEM_WIDTH = 32,
   parameter int FRAC_BITS  = 16,
   localparam int CW = 2 * ELEM_WIDTH + 1,
   localparam int DW = 3 * ELEM_WIDTH + 2,
   localparam int QW = NUM_ELEMS * CW + DW + FLAG_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [QW-1:0]      q_data,
   input  mi_fifo_status_type q_status,
   output logic               q_pop,
   mat3_rsp_if.source         rsp_chan
);

   localparam int EW  = ELEM_WIDTH;
   localparam int NW  = CW + 2 * FRAC_BITS;
   localparam int RW0 = (NW > DW + EW) ? NW : DW + EW;
   localparam int RW  = RW0 + 1;
   localparam logic [EW-1:0] MAX_VAL = {1'b0, {(EW-1){1'b1}}};
   localparam logic [EW-1:0] MIN_VAL = {1'b1, {(EW-1){1'b0}}};

   logic             back_adv;
   logic [EW:0]      vld_ff;
   logic [RW-1:0]    nmag_in [NUM_ELEMS];
   logic [RW-1:0]    rem_in [EW+1][NUM_ELEMS];
   logic [RW-1:0]    rem_ff [EW+1][NUM_ELEMS];
   logic [EW-1:0]    quo_in [EW+1][NUM_ELEMS];
   logic [EW-1:0]    quo_ff [EW+1][NUM_ELEMS];
   logic             neg_in [NUM_ELEMS];
   logic             ovf_in [NUM_ELEMS];
   logic             neg_ff [EW+1][NUM_ELEMS];
   logic             ovf_ff [EW+1][NUM_ELEMS];
   logic [DW-1:0]    dmag_ff [EW+1];
   logic             sing_ff [EW+1];
   mi_det_flags_type flags;
   logic [DW-1:0]    dmag;

   logic signed [EW-1:0] inv_in [NUM_ELEMS];
   logic signed [EW-1:0] inv_ff [NUM_ELEMS];
   logic                 sat_in;
   logic                 sat_ff;
   logic                 sing_out_ff;
   logic                 out_vld_ff;

   // The back pipeline advances as one while the output register can take a transfer.
   assign back_adv = !out_vld_ff || rsp_chan.ready;
   assign q_pop    = back_adv && !q_status.empty;
   assign dmag     = q_data[NUM_ELEMS*CW +: DW];
   assign flags    = q_data[NUM_ELEMS*CW+DW +: FLAG_BITS];

   // Entry stage: numerator magnitude, quotient sign and the out-of-range test.
   always_comb begin
      logic signed [CW-1:0] cof;
      logic signed [NW-1:0] num;
      logic [NW-1:0]        nmag;
      for (int k = 0; k < NUM_ELEMS; k++) begin
         cof          = q_data[k*CW +: CW];
         num          = NW'(cof) <<< (2 * FRAC_BITS);
         nmag         = num[NW-1] ? NW'(-num) : NW'(num);
         neg_in[k]    = num[NW-1] ^ flags.det_neg;
         nmag_in[k]   = RW'(nmag);
         ovf_in[k]    = (RW'(nmag) >= (RW'(dmag) << EW));
      end
   end

   // Restoring division, one quotient bit per stage, most significant first.
   always_comb begin
      logic [RW-1:0] trial;
      logic          ge;
      for (int k = 0; k < NUM_ELEMS; k++) begin
         rem_in[0][k] = nmag_in[k];
         quo_in[0][k] = '0;
      end
      for (int s = 1; s <= EW; s++) begin
         for (int k = 0; k < NUM_ELEMS; k++) begin
            trial        = RW'(dmag_ff[s-1]) << (EW - s);
            ge           = (rem_ff[s-1][k] >= trial);
            rem_in[s][k] = ge ? rem_ff[s-1][k] - trial : rem_ff[s-1][k];
            quo_in[s][k] = {quo_ff[s-1][k][EW-2:0], ge};
         end
      end
   end

   // Sign, saturation and the singular override on the final quotient.
   always_comb begin
      logic [EW-1:0] quo;
      sat_in = 1'b0;
      for (int k = 0; k < NUM_ELEMS; k++) begin
         quo = quo_ff[EW][k];
         priority if (sing_ff[EW]) begin
            inv_in[k] = '0;
         end else if (!neg_ff[EW][k]) begin
            if (ovf_ff[EW][k] || quo[EW-1]) begin
               inv_in[k] = MAX_VAL;
               sat_in    = 1'b1;
            end else begin
               inv_in[k] = quo;
            end
         end else begin
            if (ovf_ff[EW][k] || (quo > MIN_VAL)) begin
               inv_in[k] = MIN_VAL;
               sat_in    = 1'b1;
            end else begin
               inv_in[k] = -quo;
            end
         end
      end
   end

   // Stage and output valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (back_adv) begin
         vld_ff     <= {vld_ff[EW-1:0], !q_status.empty};
         out_vld_ff <= vld_ff[EW];
      end
   end

   // Stage payload registers.
   always_ff @(posedge clock) begin
      if (back_adv) begin
         rem_ff     <= rem_in;
         quo_ff     <= quo_in;
         neg_ff[0]  <= neg_in;
         ovf_ff[0]  <= ovf_in;
         dmag_ff[0] <= dmag;
         sing_ff[0] <= flags.singular;
         for (int s = 1; s <= EW; s++) begin
            neg_ff[s]  <= neg_ff[s-1];
            ovf_ff[s]  <= ovf_ff[s-1];
            dmag_ff[s] <= dmag_ff[s-1];
            sing_ff[s] <= sing_ff[s-1];
         end
         inv_ff      <= inv_in;
         sat_ff      <= sat_in;
         sing_out_ff <= sing_ff[EW];
      end
   end

   assign rsp_chan.valid         = out_vld_ff;
   assign rsp_chan.inv_col0_row0 = inv_ff[0];
   assign rsp_chan.inv_col0_row1 = inv_ff[1];
   assign rsp_chan.inv_col0_row2 = inv_ff[2];
   assign rsp_chan.inv_col1_row0 = inv_ff[3];
   assign rsp_chan.inv_col1_row1 = inv_ff[4];
   assign rsp_chan.inv_col1_row2 = inv_ff[5];
   assign rsp_chan.inv_col2_row0 = inv_ff[6];
   assign rsp_chan.inv_col2_row1 = inv_ff[7];
   assign rsp_chan.inv_col2_row2 = inv_ff[8];
   assign rsp_chan.singular      = sing_out_ff;
   assign rsp_chan.saturated     = sat_ff;

endmodule

[rtl/core/mat3_inverse_unit.sv]
// Top level of the 3x3 fixed-point matrix inverse unit.
// Depends on mi_pkg, the channel interfaces, mi_front, mi_queue and mi_back.
//
//   channel    direction  transfer carries
//   req_chan   in         nine matrix elements, column-major
//   rsp_chan   out        nine inverse elements, singular, saturated
//
// One matrix is taken per cycle while the queue has room; a result passes
// through the front end, queue and one-bit-per-stage back-end divider.
// Reset is synchronous and clears only valid bits, queue pointers and count.
// A stalled response holds the back end; the front end keeps taking
// transfers until the queue between them (QUEUE_DEPTH entries) fills.
module mat3_inverse_unit import mi_pkg::*; #(
   parameter int ELEM_WIDTH  = 32,
   parameter int FRAC_BITS   = 16,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   mat3_req_if.sink   req_chan,
   mat3_rsp_if.source rsp_chan
);

   localparam int CW = 2 * ELEM_WIDTH + 1;
   localparam int DW = 3 * ELEM_WIDTH + 2;
   localparam int QW = NUM_ELEMS * CW + DW + FLAG_BITS;

   logic               q_push;
   logic               q_pop;
   logic [QW-1:0]      q_push_data;
   logic [QW-1:0]      q_pop_data;
   mi_fifo_status_type q_status;

   // Cofactors and determinant.
   mi_front #(.ELEM_WIDTH(ELEM_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_status (q_status),
      .q_push   (q_push),
      .q_data   (q_push_data)
   );

   // Decoupling queue.
   mi_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // Division, saturation and output register.
   mi_back #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_data   (q_pop_data),
      .q_status (q_status),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

[rtl/core/mat3_inverse_checker.sv]
// Port-level checks on the response channel of the matrix inverse unit,
// bound to the top level. Depends on assert_macros.svh.
`include "assert_macros.svh"

module mat3_inverse_checker #(
   parameter int ELEM_WIDTH = 32
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_singular,
   input logic                  rsp_saturated,
   input logic [ELEM_WIDTH-1:0] rsp_diag0,
   input logic [ELEM_WIDTH-1:0] rsp_diag1,
   input logic [ELEM_WIDTH-1:0] rsp_diag2
);

   logic rsp_stall;
   logic sing_shown;
   logic diag_zero;

   // Conditions shared by the checks below.
   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign sing_shown = rsp_valid && rsp_singular;
   assign diag_zero  = (rsp_diag0 == '0) && (rsp_diag1 == '0) && (rsp_diag2 == '0);

   // A stalled response stays offered.
   `MI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid, "stalled response dropped")

   // Nothing is offered straight after reset.
   `MI_ASSERT_NOW(a_rsp_reset, clock, reset, $past(reset), !rsp_valid, "offered after reset")

   // A singular matrix never reports clipping.
   `MI_ASSERT_NOW(a_sing_nosat, clock, reset, sing_shown, !rsp_saturated, "singular and saturated")

   // A singular matrix gives a zero diagonal in the inverse.
   `MI_ASSERT_NOW(a_sing_zero, clock, reset, sing_shown, diag_zero, "singular result not zero")

endmodule

bind mat3_inverse_unit mat3_inverse_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_singular  (rsp_chan.singular),
   .rsp_saturated (rsp_chan.saturated),
   .rsp_diag0     (rsp_chan.inv_col0_row0),
   .rsp_diag1     (rsp_chan.inv_col1_row1),
   .rsp_diag2     (rsp_chan.inv_col2_row2)
);

[bench/mat3_inverse_checker.sv]
// Checker for the 3x3 matrix inverse unit: watches both channels, predicts
// each inverse from the accepted matrix and compares it with the response.
// Depends on the channel interfaces in rtl/core/mat3_if.sv.
`timescale 1ns / 100ps

module mat3_inverse_scoreboard #(
   parameter int ELEM_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic      clock,
   input  logic      reset,
   mat3_req_if.sink  req_mon,
   mat3_rsp_if.sink  rsp_mon,
   output int        error_count,
   output int        pending_count
);

   typedef logic signed [ELEM_WIDTH-1:0] elem_type;
   typedef logic signed [255:0] wide_type;

   typedef struct {
      elem_type inv [9];
      logic     singular;
      logic     saturated;
   } inverse_type;

   inverse_type expected_inverses [$];

   // Exact cofactor, determinant and saturating division at 256 bits.
   function automatic inverse_type compute_inverse(elem_type m [9]);
      wide_type    v [9];
      wide_type    cof [9];
      wide_type    det, dmag, num, nmag, quot, lim;
      logic        neg;
      inverse_type r;
      for (int i = 0; i < 9; i++) v[i] = 256'(m[i]);
      cof[0] = v[4]*v[8] - v[7]*v[5];
      cof[1] = v[7]*v[2] - v[1]*v[8];
      cof[2] = v[1]*v[5] - v[4]*v[2];
      cof[3] = v[6]*v[5] - v[3]*v[8];
      cof[4] = v[0]*v[8] - v[6]*v[2];
      cof[5] = v[3]*v[2] - v[0]*v[5];
      cof[6] = v[3]*v[7] - v[6]*v[4];
      cof[7] = v[6]*v[1] - v[0]*v[7];
      cof[8] = v[0]*v[4] - v[3]*v[1];
      det = v[0]*cof[0] + v[3]*cof[1] + v[6]*cof[2];
      r.singular = (det == 0);
      r.saturated = 1'b0;
      for (int i = 0; i < 9; i++) r.inv[i] = '0;
      if (r.singular) return r;
      dmag = det < 0 ? -det : det;
      lim = wide_type'(1) <<< (ELEM_WIDTH - 1);
      for (int i = 0; i < 9; i++) begin
         num = cof[i] <<< (2 * FRAC_BITS);
         nmag = num < 0 ? -num : num;
         quot = nmag / dmag;
         neg = (num < 0) != (det < 0);
         if (!neg && quot >= lim) begin
            r.inv[i] = elem_type'(lim - 1);
            r.saturated = 1'b1;
         end else if (neg && quot > lim) begin
            r.inv[i] = elem_type'(-lim);
            r.saturated = 1'b1;
         end else begin
            r.inv[i] = elem_type'(neg ? -quot : quot);
         end
      end
      return r;
   endfunction

   // Record an expectation per request transfer, check each response transfer.
   always @(posedge clock) begin
      elem_type    m [9];
      elem_type    got [9];
      inverse_type want;
      int          errs;
      errs = 0;
      if (reset) begin
         error_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            m = '{req_mon.col0_row0, req_mon.col0_row1, req_mon.col0_row2,
                  req_mon.col1_row0, req_mon.col1_row1, req_mon.col1_row2,
                  req_mon.col2_row0, req_mon.col2_row1, req_mon.col2_row2};
            expected_inverses.push_back(compute_inverse(m));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_inverses.size() == 0) begin
               $error("response transfer with no matrix outstanding");
               errs++;
            end else begin
               want = expected_inverses.pop_front();
               got = '{rsp_mon.inv_col0_row0, rsp_mon.inv_col0_row1,
                       rsp_mon.inv_col0_row2, rsp_mon.inv_col1_row0,
                       rsp_mon.inv_col1_row1, rsp_mon.inv_col1_row2,
                       rsp_mon.inv_col2_row0, rsp_mon.inv_col2_row1,
                       rsp_mon.inv_col2_row2};
               for (int i = 0; i < 9; i++)
                  if (got[i] !== want.inv[i]) begin
                     $error("inv_col%0d_row%0d: expected %0d, got %0d",
                            i / 3, i % 3, want.inv[i], got[i]);
                     errs++;
                  end
               if (rsp_mon.singular !== want.singular) begin
                  $error("singular: expected %0b, got %0b", want.singular,
                         rsp_mon.singular);
                  errs++;
               end
               if (rsp_mon.saturated !== want.saturated) begin
                  $error("saturated: expected %0b, got %0b", want.saturated,
                         rsp_mon.saturated);
                  errs++;
               end
            end
         end
         error_count <= error_count + errs;
      end
      pending_count <= expected_inverses.size();
   end

endmodule

[bench/tb.sv]
// Top of the matrix inverse testbench: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on mi_pkg, the channel
// interfaces, mat3_inverse_unit and mat3_inverse_scoreboard.
`timescale 1ns / 100ps

module tb;

   localparam int ELEM_WIDTH   = 32;
   localparam int FRAC_BITS    = 16;
   localparam int RANDOM_ITEMS = 600;
   localparam int CYCLE_LIMIT  = 400000;

   typedef logic signed [ELEM_WIDTH-1:0] elem_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   error_count;
   int   pending_count;
   logic calm_phase = 1'b0;
   logic long_hold = 1'b0;

   mat3_req_if #(.ELEM_WIDTH(ELEM_WIDTH)) req_chan ();
   mat3_rsp_if #(.ELEM_WIDTH(ELEM_WIDTH)) rsp_chan ();

   mat3_inverse_unit #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan));

   mat3_inverse_scoreboard #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) checker_inst (
      .clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .error_count(error_count), .pending_count(pending_count));

   // Clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Cycle counter with a generous timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Pick one element: extremes, small signed values or any pattern.
   function automatic elem_type random_elem();
      case ($urandom_range(0, 5))
         0:       return elem_type'($urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff);
         1:       return elem_type'(($urandom_range(0, 8) - 4) <<< FRAC_BITS);
         2:       return elem_type'($signed($urandom_range(0, 2047)) - 1024);
         3:       return elem_type'($signed($urandom_range(0, 32'h7ffff)) - 32'h40000);
         default: return elem_type'($urandom);
      endcase
   endfunction

   // Drive one matrix and hold it until the transfer happens.
   task automatic send_matrix(elem_type m [9]);
      req_chan.valid <= 1'b1;
      {req_chan.col0_row0, req_chan.col0_row1, req_chan.col0_row2,
       req_chan.col1_row0, req_chan.col1_row1, req_chan.col1_row2,
       req_chan.col2_row0, req_chan.col2_row1, req_chan.col2_row2} <=
         {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // Random idle burst on the request side, except in the calm phase.
   task automatic maybe_idle();
      if (!calm_phase && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   endtask

   // Response back-pressure: random stall bursts, one long hold-off.
   initial begin
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_chan.ready <= 1'b0;
            repeat (200) @(negedge clock);
            long_hold = 1'b0;
         end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      elem_type m [9];
      int       unit = 1 <<< FRAC_BITS;
      req_chan.valid = 1'b0;
      {req_chan.col0_row0, req_chan.col0_row1, req_chan.col0_row2,
       req_chan.col1_row0, req_chan.col1_row1, req_chan.col1_row2,
       req_chan.col2_row0, req_chan.col2_row1, req_chan.col2_row2} = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: identity, scaled identities, zero, singular, extremes.
      m = '{unit, 0, 0, 0, unit, 0, 0, 0, unit};        send_matrix(m);
      m = '{2*unit, 0, 0, 0, -4*unit, 0, 0, 0, unit/2}; send_matrix(m);
      m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                 send_matrix(m);
      m = '{unit, 2*unit, 3*unit, 2*unit, 4*unit, 6*unit, 1, 5, 7}; send_matrix(m);
      m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                 send_matrix(m);
      m = '{-1, 0, 0, 0, -1, 0, 0, 0, -1};              send_matrix(m);
      for (int i = 0; i < 9; i++) m[i] = elem_type'(32'h7fff_ffff);
      send_matrix(m);
      for (int i = 0; i < 9; i++) m[i] = elem_type'(32'h8000_0000);
      send_matrix(m);
      m = '{elem_type'(32'h7fff_ffff), 0, 0, 0, elem_type'(32'h8000_0000), 0, 0, 0,
            elem_type'(32'h7fff_ffff)};
      send_matrix(m);
      m = '{elem_type'(32'h8000_0000), 0, 0, 0, elem_type'(32'h8000_0000), 0, 0, 0,
            elem_type'(32'h8000_0000)};
      send_matrix(m);
      m = '{0, unit, 0, unit, 0, 0, 0, 0, -unit};       send_matrix(m);
      m = '{3, -7, 2, 9, 1, -5, -4, 8, 6};              send_matrix(m);

      // Random matrices, with a long response hold-off part way through.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 150) long_hold = 1'b1;
         if (n == 300) begin
            // Sender pauses until every outstanding inverse has arrived.
            req_chan.valid <= 1'b0;
            while (pending_count != 0) @(negedge clock);
         end
         if (n == RANDOM_ITEMS - 100) calm_phase = 1'b1;
         for (int i = 0; i < 9; i++) m[i] = random_elem();
         if ($urandom_range(0, 9) == 0) begin
            // Repeated column makes a singular matrix.
            m[3] = m[0]; m[4] = m[1]; m[5] = m[2];
         end
         send_matrix(m);
         maybe_idle();
      end
      req_chan.valid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (ELEM_WIDTH + 20) @(negedge clock);
      if (error_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
